// ===== rtl/mrcl_pkg.sv =====
// ----------------------------------------------------------------------------
// mrcl_pkg
// Shared types, codes and constants of the modulation ramp current limiter.
// ----------------------------------------------------------------------------
package mrcl_pkg;

    // Command codes carried in s_tuser
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_DIRECT = 2'd2;
    localparam logic [1:0] CMD_CANCEL = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_CLAMP_LIMIT  = 2'd0;
    localparam logic [1:0] REG_DEFAULT_LIM  = 2'd1;
    localparam logic [1:0] REG_PAUSE_TMO    = 2'd2;

    localparam int MAX_TICK_GAP_MS_DEF = 500;
    localparam int MOD_FRAC_BITS_DEF   = 14;

    localparam logic [15:0] CLAMP_LIMIT_RST = 16'd1000;
    localparam logic [15:0] DEFAULT_LIM_RST = 16'd1000;
    localparam logic [15:0] PAUSE_TMO_RST   = 16'd2000;

    // Per-millisecond factors in Q32: exp(-1/20) and exp(-1/500)
    localparam logic [63:0] FAST_Q32 = 64'd4085499269;
    localparam logic [63:0] SLOW_Q32 = 64'd4286385946;

    localparam int IN_W  = 136;
    localparam int OUT_W = 24;

    typedef logic [16:0] mag_t;

    // Magnitude of a 17-bit signed value
    function automatic mag_t mag17(input logic signed [16:0] x);
        mag17 = x[16] ? mag_t'(-x) : mag_t'(x);
    endfunction

    // Q16 factor for a gap of d ms, elaboration only
    function automatic logic [16:0] rom_entry(input int d, input logic [63:0] f,
                                              input bit rise);
        logic [95:0] p;
        logic [95:0] t;
        logic [16:0] r;
        p = 96'd1 << 32;
        for (int i = 1; i <= d; i++) begin
            t = p * f + (96'd1 << 31);
            p = t >> 32;
        end
        r = 17'((p + 96'd32768) >> 16);
        rom_entry = rise ? 17'(17'd65536 - r) : r;
    endfunction

endpackage

// ===== rtl/modulation_ramp_current_limiter_core.sv =====
// ----------------------------------------------------------------------------
// modulation_ramp_current_limiter_core
// Ramp supervisor for the modulation index with an overcurrent ceiling.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one request per command. s_tuser holds the command (tick,
//   start ramp, direct set, cancel), s_tdata the time stamp, phase currents
//   and ramp fields. m_ channel: one result per request with the modulation
//   sent to the PWM and the ramp status flags.
//   cfg_ channel: register writes (clamp limit, default ramp limit, pause
//   timeout), taken in any cycle; write them only while the block is idle.
// Sequencing:
//   A tick request while a ramp runs goes through a ROM read, two passes
//   through one shared 17x16 multiplier, then a 16-step restoring divider
//   for the ramp point. A tick with no ramp stops after the ceiling update,
//   other commands go straight to the result. s_tready is high only while
//   no request is in work or waiting, so one request is handled at a time.
// Reset:
//   aresetn clears the ramp, sets the ceiling to all ones and reloads the
//   register defaults. No clearing pass is needed.
// Stall:
//   While m_tready is low the result is held and no request is taken.
// ----------------------------------------------------------------------------
module modulation_ramp_current_limiter_core #(
    parameter int MAX_TICK_GAP_MS = mrcl_pkg::MAX_TICK_GAP_MS_DEF,
    parameter int MOD_FRAC_BITS   = mrcl_pkg::MOD_FRAC_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // now_ms[31:0], current_u[47:32], current_v[63:48], start_mod[79:64],
    // target_mod[95:80], ramp_ms[111:96], ramp_limit[127:112],
    // arm_estimator[128], zero fill
    input  logic [mrcl_pkg::IN_W-1:0]  s_tdata,
    // cmd[1:0]
    input  logic [1:0]                 s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // mod_out[15:0], pwm_write[16], ramping[17], paused[18], ramp_done[19],
    // estimator_enable[20], overcurrent_abort[21], zero fill
    output logic [mrcl_pkg::OUT_W-1:0] m_tdata,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [15:0]                cfg_data
);

    localparam int IDX_W = $clog2(MAX_TICK_GAP_MS + 1);
    localparam logic [63:0] DIRECT_LIM64 =
        (64'd1154700538 * (64'd1 << MOD_FRAC_BITS) + 64'd500000000) / 64'd1000000000;
    localparam logic [15:0] DIRECT_LIM = DIRECT_LIM64[15:0];
    localparam logic [31:0] NEAR_LIM = 32'd1 << MOD_FRAC_BITS;

    typedef logic [16:0] rom_t [0:MAX_TICK_GAP_MS];

    function automatic rom_t build_rom(input bit rise);
        rom_t r;
        for (int d = 0; d <= MAX_TICK_GAP_MS; d++) begin
            r[d] = mrcl_pkg::rom_entry(d, rise ? mrcl_pkg::SLOW_Q32 : mrcl_pkg::FAST_Q32,
                                       rise);
        end
        build_rom = r;
    endfunction

    localparam rom_t KEEP_ROM = build_rom(1'b0);
    localparam rom_t RISE_ROM = build_rom(1'b1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CMD   = 4'd1;
    localparam logic [3:0] ST_ROM   = 4'd2;
    localparam logic [3:0] ST_MULC  = 4'd3;
    localparam logic [3:0] ST_CLAMP = 4'd4;
    localparam logic [3:0] ST_MULR  = 4'd5;
    localparam logic [3:0] ST_DIV   = 4'd6;
    localparam logic [3:0] ST_RAMP  = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic [15:0] clamp_lim_reg, clamp_lim_next, def_lim_reg, def_lim_next;
    logic [15:0] tmo_reg, tmo_next;
    logic [1:0]  cmd_reg, cmd_next;
    logic [31:0] now_reg, now_next;
    logic [15:0] smod_reg, smod_next, tmod_reg, tmod_next;
    logic [15:0] rms_reg, rms_next, rlim_reg, rlim_next;
    logic        arm_reg, arm_next;
    logic [16:0] peak_reg, peak_next;
    logic [15:0] applied_reg, applied_next, ceil_reg, ceil_next;
    logic [31:0] clamp_time_reg, clamp_time_next;
    logic        clamp_valid_reg, clamp_valid_next;
    logic [15:0] start_reg, start_next, end_reg, end_next;
    logic [15:0] len_reg, len_next, alim_reg, alim_next;
    logic [31:0] origin_reg, origin_next, pbegin_reg, pbegin_next;
    logic        active_reg, active_next, paused_reg, paused_next;
    logic        armed_reg, armed_next;
    logic        use_reg, use_next, decay_reg, decay_next, recov_reg, recov_next;
    logic [32:0] prod_reg, prod_next;
    logic [15:0] elapsed_reg, elapsed_next, span_reg, span_next;
    logic [15:0] rem_reg, rem_next, quo_reg, quo_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        wrote_reg, wrote_next, done_reg, done_next;
    logic        est_reg, est_next, abort_reg, abort_next;
    logic [16:0] keep_q, rise_q;
    logic [IDX_W-1:0] rom_idx;

    logic [31:0] dt;
    logic        dt_use;
    logic [16:0] mul_a;
    logic [16:0] mul_b;
    logic [32:0] mul_p;
    logic [20:0] peak_x10;
    logic [18:0] clim_x8, alim_x8;
    logic signed [16:0] in_u, in_v, in_w;
    logic [16:0] t_div;
    logic        div_ge;
    logic [15:0] desired;
    logic        over, paused_new;
    logic [31:0] pb_eff, elapsed_full;
    logic [15:0] diff;
    logic [29:0] diff_x;
    logic [15:0] mod_sel;

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_OUT);
    assign cfg_ready = 1'b1;

    assign dt      = now_reg - clamp_time_reg;
    assign dt_use  = clamp_valid_reg && (dt != 32'd0) && (dt <= 32'(MAX_TICK_GAP_MS));
    assign rom_idx = dt_use ? dt[IDX_W-1:0] : '0;

    assign peak_x10 = {peak_reg, 3'b000} + {2'b00, peak_reg, 1'b0};
    assign clim_x8  = {clamp_lim_reg, 3'b000};
    assign alim_x8  = {alim_reg, 3'b000};

    assign in_u = 17'(signed'(s_tdata[47:32]));
    assign in_v = 17'(signed'(s_tdata[63:48]));
    assign in_w = -(in_u + in_v);

    // Shared multiplier: ceiling update, then ramp numerator
    always_comb begin
        if (state_reg == ST_MULR) begin
            mul_a = {1'b0, span_reg};
            mul_b = {1'b0, elapsed_reg};
        end else if (decay_next) begin
            mul_a = {1'b0, ceil_reg};
            mul_b = keep_q;
        end else begin
            mul_a = {1'b0, 16'(applied_reg - ceil_reg)};
            mul_b = rise_q;
        end
    end
    assign mul_p = 33'(mul_a[15:0] * mul_b);

    assign t_div  = {rem_reg, quo_reg[15]};
    assign div_ge = t_div >= {1'b0, len_reg};

    assign elapsed_full = now_reg - origin_reg;
    assign diff   = (smod_reg >= tmod_reg) ? 16'(smod_reg - tmod_reg)
                                           : 16'(tmod_reg - smod_reg);
    assign diff_x = 30'(diff * 14'd10000);

    always_comb begin
        if (len_reg == 16'd0) begin
            desired = end_reg;
        end else if (end_reg >= start_reg) begin
            desired = 16'(start_reg + quo_reg);
        end else begin
            desired = 16'(start_reg - quo_reg);
        end
    end
    assign over       = (peak_reg > alim_reg) && (desired > applied_reg);
    assign pb_eff     = (over && !paused_reg) ? now_reg : pbegin_reg;
    assign paused_new = over || (paused_reg && !(peak_x10 <= {2'b00, alim_x8}));

    always_comb begin
        state_next       = state_reg;
        clamp_lim_next   = clamp_lim_reg;
        def_lim_next     = def_lim_reg;
        tmo_next         = tmo_reg;
        cmd_next         = cmd_reg;
        now_next         = now_reg;
        smod_next        = smod_reg;
        tmod_next        = tmod_reg;
        rms_next         = rms_reg;
        rlim_next        = rlim_reg;
        arm_next         = arm_reg;
        peak_next        = peak_reg;
        applied_next     = applied_reg;
        ceil_next        = ceil_reg;
        clamp_time_next  = clamp_time_reg;
        clamp_valid_next = clamp_valid_reg;
        start_next       = start_reg;
        end_next         = end_reg;
        len_next         = len_reg;
        alim_next        = alim_reg;
        origin_next      = origin_reg;
        pbegin_next      = pbegin_reg;
        active_next      = active_reg;
        paused_next      = paused_reg;
        armed_next       = armed_reg;
        use_next         = use_reg;
        decay_next       = decay_reg;
        recov_next       = recov_reg;
        prod_next        = prod_reg;
        elapsed_next     = elapsed_reg;
        span_next        = span_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        cnt_next         = cnt_reg;
        wrote_next       = wrote_reg;
        done_next        = done_reg;
        est_next         = est_reg;
        abort_next       = abort_reg;

        if (cfg_valid) begin
            case (cfg_index)
                mrcl_pkg::REG_CLAMP_LIMIT: clamp_lim_next = cfg_data;
                mrcl_pkg::REG_DEFAULT_LIM: def_lim_next   = cfg_data;
                mrcl_pkg::REG_PAUSE_TMO:   tmo_next       = cfg_data;
                default: ;
            endcase
        end

        if (state_reg == ST_MULC) begin
            decay_next = use_reg && (peak_reg > {1'b0, clamp_lim_reg});
            recov_next = use_reg && !(peak_reg > {1'b0, clamp_lim_reg}) &&
                         (peak_x10 < {2'b00, clim_x8}) && (ceil_reg < applied_reg);
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = s_tuser;
                    now_next   = s_tdata[31:0];
                    smod_next  = s_tdata[79:64];
                    tmod_next  = s_tdata[95:80];
                    rms_next   = s_tdata[111:96];
                    rlim_next  = s_tdata[127:112];
                    arm_next   = s_tdata[128];
                    peak_next  = mrcl_pkg::mag17(in_u);
                    if (mrcl_pkg::mag17(in_v) > peak_next) begin
                        peak_next = mrcl_pkg::mag17(in_v);
                    end
                    if (mrcl_pkg::mag17(in_w) > peak_next) begin
                        peak_next = mrcl_pkg::mag17(in_w);
                    end
                    wrote_next = 1'b0;
                    done_next  = 1'b0;
                    est_next   = 1'b0;
                    abort_next = 1'b0;
                    state_next = (s_tuser == mrcl_pkg::CMD_TICK) ? ST_ROM : ST_CMD;
                end
            end
            ST_CMD: begin
                case (cmd_reg)
                    mrcl_pkg::CMD_START: begin
                        start_next  = smod_reg;
                        end_next    = tmod_reg;
                        len_next    = rms_reg;
                        alim_next   = (rlim_reg != 16'd0) ? rlim_reg : def_lim_reg;
                        armed_next  = armed_reg || arm_reg;
                        origin_next = now_reg;
                        paused_next = 1'b0;
                        pbegin_next = 32'd0;
                        active_next = 1'b1;
                        if ((rms_reg == 16'd0) || (32'(diff_x) < NEAR_LIM)) begin
                            // finish at once
                            active_next  = 1'b0;
                            applied_next = tmod_reg;
                            wrote_next   = 1'b1;
                            done_next    = 1'b1;
                            est_next     = armed_reg || arm_reg;
                            armed_next   = 1'b0;
                        end
                    end
                    mrcl_pkg::CMD_DIRECT: begin
                        applied_next = (tmod_reg > DIRECT_LIM) ? DIRECT_LIM : tmod_reg;
                        active_next  = 1'b0;
                        paused_next  = 1'b0;
                        armed_next   = 1'b0;
                        wrote_next   = 1'b1;
                    end
                    default: begin
                        active_next = 1'b0;
                        paused_next = 1'b0;
                        armed_next  = 1'b0;
                    end
                endcase
                state_next = ST_OUT;
            end
            ST_ROM: begin
                use_next         = dt_use;
                clamp_time_next  = now_reg;
                clamp_valid_next = 1'b1;
                state_next       = ST_MULC;
            end
            ST_MULC: begin
                prod_next  = mul_p;
                state_next = ST_CLAMP;
            end
            ST_CLAMP: begin
                if (decay_reg) begin
                    ceil_next = 16'((prod_reg + 33'd32768) >> 16);
                end else if (recov_reg) begin
                    ceil_next = 16'(ceil_reg + 16'((prod_reg + 33'd32768) >> 16));
                end
                elapsed_next = (elapsed_full > {16'd0, len_reg}) ? len_reg
                                                                 : elapsed_full[15:0];
                span_next    = (end_reg >= start_reg) ? 16'(end_reg - start_reg)
                                                      : 16'(start_reg - end_reg);
                quo_next     = 16'd0;
                if (!active_reg) begin
                    state_next = ST_OUT;
                end else if (len_reg == 16'd0) begin
                    state_next = ST_RAMP;
                end else begin
                    state_next = ST_MULR;
                end
            end
            ST_MULR: begin
                prod_next  = mul_p + {18'd0, len_reg[15:1]};
                rem_next   = prod_next[31:16];
                quo_next   = prod_next[15:0];
                cnt_next   = 4'd0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                rem_next = div_ge ? 16'(t_div - {1'b0, len_reg}) : t_div[15:0];
                quo_next = {quo_reg[14:0], div_ge};
                cnt_next = 4'(cnt_reg + 4'd1);
                if (cnt_reg == 4'd15) begin
                    state_next = ST_RAMP;
                end
            end
            ST_RAMP: begin
                if (over) begin
                    paused_next = 1'b1;
                    pbegin_next = pb_eff;
                end else if (paused_reg && (peak_x10 <= {2'b00, alim_x8})) begin
                    // resume: stretch the timeline by the time spent paused
                    origin_next  = origin_reg + (now_reg - pbegin_reg);
                    paused_next  = 1'b0;
                    applied_next = desired;
                end else if (!paused_reg) begin
                    applied_next = desired;
                end
                if (paused_new && ((now_reg - pb_eff) >= {16'd0, tmo_reg})) begin
                    active_next = 1'b0;
                    paused_next = 1'b0;
                    armed_next  = 1'b0;
                    abort_next  = 1'b1;
                end else begin
                    wrote_next = 1'b1;
                    if ((elapsed_reg == len_reg) && !paused_new) begin
                        active_next  = 1'b0;
                        paused_next  = 1'b0;
                        applied_next = end_reg;
                        done_next    = 1'b1;
                        est_next     = armed_reg;
                        armed_next   = 1'b0;
                    end
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ROM read, registered
    always_ff @(posedge aclk) begin
        if (state_reg == ST_ROM) begin
            keep_q <= KEEP_ROM[rom_idx];
            rise_q <= RISE_ROM[rom_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            clamp_lim_reg   <= mrcl_pkg::CLAMP_LIMIT_RST;
            def_lim_reg     <= mrcl_pkg::DEFAULT_LIM_RST;
            tmo_reg         <= mrcl_pkg::PAUSE_TMO_RST;
            applied_reg     <= 16'd0;
            ceil_reg        <= 16'hFFFF;
            clamp_time_reg  <= 32'd0;
            clamp_valid_reg <= 1'b0;
            start_reg       <= 16'd0;
            end_reg         <= 16'd0;
            len_reg         <= 16'd0;
            alim_reg        <= 16'd0;
            origin_reg      <= 32'd0;
            pbegin_reg      <= 32'd0;
            active_reg      <= 1'b0;
            paused_reg      <= 1'b0;
            armed_reg       <= 1'b0;
            wrote_reg       <= 1'b0;
            done_reg        <= 1'b0;
            est_reg         <= 1'b0;
            abort_reg       <= 1'b0;
            cnt_reg         <= 4'd0;
        end else begin
            state_reg       <= state_next;
            clamp_lim_reg   <= clamp_lim_next;
            def_lim_reg     <= def_lim_next;
            tmo_reg         <= tmo_next;
            applied_reg     <= applied_next;
            ceil_reg        <= ceil_next;
            clamp_time_reg  <= clamp_time_next;
            clamp_valid_reg <= clamp_valid_next;
            start_reg       <= start_next;
            end_reg         <= end_next;
            len_reg         <= len_next;
            alim_reg        <= alim_next;
            origin_reg      <= origin_next;
            pbegin_reg      <= pbegin_next;
            active_reg      <= active_next;
            paused_reg      <= paused_next;
            armed_reg       <= armed_next;
            wrote_reg       <= wrote_next;
            done_reg        <= done_next;
            est_reg         <= est_next;
            abort_reg       <= abort_next;
            cnt_reg         <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        now_reg     <= now_next;
        smod_reg    <= smod_next;
        tmod_reg    <= tmod_next;
        rms_reg     <= rms_next;
        rlim_reg    <= rlim_next;
        arm_reg     <= arm_next;
        peak_reg    <= peak_next;
        use_reg     <= use_next;
        decay_reg   <= decay_next;
        recov_reg   <= recov_next;
        prod_reg    <= prod_next;
        elapsed_reg <= elapsed_next;
        span_reg    <= span_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
    end

    assign mod_sel = abort_reg ? 16'd0
                   : ((applied_reg < ceil_reg) ? applied_reg : ceil_reg);
    assign m_tdata = {2'b00, abort_reg, est_reg, done_reg, paused_reg, active_reg,
                      wrote_reg, mod_sel};

    a_paused_active: assert property (@(posedge aclk) disable iff (!aresetn)
        paused_reg |-> active_reg)
        else $error("paused without active ramp");

    a_done_abort: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(done_reg && abort_reg))
        else $error("ramp done and abort together");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && done_reg) |-> (!active_reg && wrote_reg))
        else $error("ramp done but still active");

    a_abort_nowrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && abort_reg) |-> (!wrote_reg && m_tdata[15:0] == 16'd0))
        else $error("abort with PWM write");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modulation ramp current limiter testbench
// Drives ticks, ramp starts, direct sets and cancels through the request
// stream under random idling on both sides, predicts every result in a
// cycle-free model of the supervisor and checks each one field by field.
// Register settings are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;

    localparam int GAP_MAX   = mrcl_pkg::MAX_TICK_GAP_MS_DEF;
    localparam int FRAC      = mrcl_pkg::MOD_FRAC_BITS_DEF;
    localparam int CYC_LIMIT = 600000;

    typedef struct {
        logic [1:0]         cmd;
        logic [31:0]        now;
        logic signed [15:0] cu;
        logic signed [15:0] cv;
        logic [15:0]        smod;
        logic [15:0]        tmod;
        logic [15:0]        rms;
        logic [15:0]        rlim;
        logic               arm;
        bit                 drain;
    } cmd_item_t;

    typedef struct {
        logic [15:0] mod;
        logic        wr;
        logic        rmp;
        logic        pau;
        logic        done;
        logic        est;
        logic        abrt;
    } status_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [mrcl_pkg::IN_W-1:0] s_tdata = '0;
    logic [1:0]                s_tuser = mrcl_pkg::CMD_TICK;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [mrcl_pkg::OUT_W-1:0] m_tdata;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [1:0]                cfg_index = mrcl_pkg::REG_CLAMP_LIMIT;
    logic [15:0]               cfg_data = '0;

    modulation_ramp_current_limiter_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 aclk = ~aclk;

    cmd_item_t pending_reqs[$];
    status_t   expected_status[$];
    int        mismatches = 0;
    int        results_seen = 0;
    int        reqs_sent = 0;
    int        aborts_seen = 0;
    int        dones_seen = 0;
    int        cycles = 0;
    bit        calm = 0;
    logic [31:0] tnow;

    // predictor state
    logic [16:0] keep_q16[0:GAP_MAX];
    logic [16:0] rise_q16[0:GAP_MAX];
    logic [15:0] lim_clamp, lim_default, tmo_ms;
    logic [15:0] applied, ceiling, r_start, r_end, r_len, r_lim;
    logic [31:0] clamp_t, r_origin, p_begin;
    bit          clamp_ok, r_act, r_pau, est_armed;

    function automatic logic [16:0] peak_of(logic signed [15:0] u, logic signed [15:0] v);
        int a, b, w, p;
        a = (u < 0) ? -int'(u) : int'(u);
        b = (v < 0) ? -int'(v) : int'(v);
        w = -(int'(u) + int'(v));
        if (w < 0) w = -w;
        p = a;
        if (b > p) p = b;
        if (w > p) p = w;
        return p[16:0];
    endfunction

    task automatic end_ramp(ref status_t s);
        r_act = 0;
        r_pau = 0;
        applied = r_end;
        s.wr = 1;
        s.done = 1;
        if (est_armed) begin
            est_armed = 0;
            s.est = 1;
        end
    endtask

    task automatic drop_ramp();
        r_act = 0;
        r_pau = 0;
        est_armed = 0;
    endtask

    task automatic ceiling_update(logic [31:0] now, logic [16:0] peak);
        logic [31:0] dt;
        logic [63:0] prod;
        bit ok;
        dt = now - clamp_t;
        ok = clamp_ok && dt != 0 && dt <= GAP_MAX;
        clamp_t = now;
        clamp_ok = 1;
        if (ok) begin
            if (peak > lim_clamp) begin
                prod = 64'(ceiling) * keep_q16[dt] + 64'd32768;
                ceiling = 16'(prod >> 16);
            end else if (64'(peak) * 10 < 64'(lim_clamp) * 8 && ceiling < applied) begin
                prod = 64'(applied - ceiling) * rise_q16[dt] + 64'd32768;
                ceiling = ceiling + 16'(prod >> 16);
            end
        end
    endtask

    task automatic ramp_advance(logic [31:0] now, logic [16:0] peak, ref status_t s);
        logic [31:0] elapsed;
        logic [63:0] span, part;
        logic [15:0] want;
        if (!r_act) return;
        elapsed = now - r_origin;
        if (elapsed > r_len) elapsed = r_len;
        if (r_len == 0) want = r_end;
        else begin
            span = (r_end >= r_start) ? 64'(r_end - r_start) : 64'(r_start - r_end);
            part = (span * elapsed + r_len / 2) / r_len;
            want = (r_end >= r_start) ? 16'(r_start + part) : 16'(r_start - part);
        end
        if (peak > r_lim && want > applied) begin
            if (!r_pau) begin
                r_pau = 1;
                p_begin = now;
            end
        end else if (r_pau && 64'(peak) * 10 <= 64'(r_lim) * 8) begin
            r_origin = r_origin + (now - p_begin);
            r_pau = 0;
            applied = want;
        end else if (!r_pau) begin
            applied = want;
        end
        if (r_pau && (now - p_begin) >= tmo_ms) begin
            drop_ramp();
            s.abrt = 1;
            return;
        end
        s.wr = 1;
        if (elapsed >= r_len && !r_pau) end_ramp(s);
    endtask

    task automatic predict_status(cmd_item_t it);
        status_t s;
        logic [16:0] peak;
        logic [15:0] diff;
        logic [15:0] direct_max;
        s = '{default: 0};
        direct_max = 16'((64'd1154700538 * (64'd1 << FRAC) + 64'd500000000) / 64'd1000000000);
        case (it.cmd)
            mrcl_pkg::CMD_TICK: begin
                peak = peak_of(it.cu, it.cv);
                ceiling_update(it.now, peak);
                ramp_advance(it.now, peak, s);
            end
            mrcl_pkg::CMD_START: begin
                diff = (it.smod >= it.tmod) ? it.smod - it.tmod : it.tmod - it.smod;
                r_start = it.smod;
                r_end = it.tmod;
                r_len = it.rms;
                r_lim = (it.rlim != 0) ? it.rlim : lim_default;
                est_armed = est_armed || it.arm;
                r_origin = it.now;
                r_pau = 0;
                p_begin = 0;
                r_act = 1;
                if (it.rms == 0 || 64'(diff) * 10000 < (64'd1 << FRAC)) begin
                    applied = it.tmod;
                    end_ramp(s);
                end
            end
            mrcl_pkg::CMD_DIRECT: begin
                applied = (it.tmod > direct_max) ? direct_max : it.tmod;
                drop_ramp();
                s.wr = 1;
            end
            default: drop_ramp();
        endcase
        s.mod = (applied < ceiling) ? applied : ceiling;
        if (s.abrt) s.mod = 0;
        s.rmp = r_act;
        s.pau = r_pau;
        expected_status.push_back(s);
    endtask

    // request driver
    always @(posedge aclk) begin : req_driver
        cmd_item_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                it.cmd = s_tuser;
                it.now = s_tdata[31:0];
                it.cu = s_tdata[47:32];
                it.cv = s_tdata[63:48];
                it.smod = s_tdata[79:64];
                it.tmod = s_tdata[95:80];
                it.rms = s_tdata[111:96];
                it.rlim = s_tdata[127:112];
                it.arm = s_tdata[128];
                predict_status(it);
                reqs_sent++;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (pending_reqs.size() > 0 &&
                    !(pending_reqs[0].drain && expected_status.size() > 0) &&
                    (calm || $urandom_range(99) >= 36)) begin
                    it = pending_reqs.pop_front();
                    s_tdata <= {7'd0, it.arm, it.rlim, it.rms, it.tmod, it.smod,
                                it.cv, it.cu, it.now};
                    s_tuser <= it.cmd;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin : res_monitor
        status_t e;
        status_t a;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                a.mod = m_tdata[15:0];
                a.wr = m_tdata[16];
                a.rmp = m_tdata[17];
                a.pau = m_tdata[18];
                a.done = m_tdata[19];
                a.est = m_tdata[20];
                a.abrt = m_tdata[21];
                results_seen++;
                if (a.abrt) aborts_seen++;
                if (a.done) dones_seen++;
                if (expected_status.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", m_tdata);
                end else begin
                    e = expected_status.pop_front();
                    if (e.mod !== a.mod || e.wr !== a.wr || e.rmp !== a.rmp ||
                        e.pau !== a.pau || e.done !== a.done || e.est !== a.est ||
                        e.abrt !== a.abrt) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: exp mod=%0d wr%b rmp%b pau%b done%b est%b abrt%b",
                                     results_seen, e.mod, e.wr, e.rmp, e.pau, e.done,
                                     e.est, e.abrt, "  got mod=%0d wr%b rmp%b pau%b done%b est%b abrt%b",
                                     a.mod, a.wr, a.rmp, a.pau, a.done, a.est, a.abrt);
                    end
                end
            end
            m_tready <= calm || ($urandom_range(99) >= 36);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic cmd_item_t mk(logic [1:0] c, logic signed [15:0] u, logic signed [15:0] v,
                                     logic [15:0] sm, logic [15:0] tm, logic [15:0] ms,
                                     logic [15:0] lim, logic arm);
        cmd_item_t it;
        it.cmd = c; it.now = tnow; it.cu = u; it.cv = v; it.smod = sm; it.tmod = tm;
        it.rms = ms; it.rlim = lim; it.arm = arm; it.drain = 0;
        return it;
    endfunction

    task automatic tick(int unsigned dt, logic signed [15:0] u, logic signed [15:0] v);
        tnow = tnow + dt;
        pending_reqs.push_back(mk(mrcl_pkg::CMD_TICK, u, v, 16'($urandom), 16'($urandom),
                                  16'($urandom), 16'($urandom), 1'($urandom_range(1))));
    endtask

    task automatic start(logic [15:0] sm, logic [15:0] tm, logic [15:0] ms,
                         logic [15:0] lim, logic arm);
        pending_reqs.push_back(mk(mrcl_pkg::CMD_START, 16'($urandom), 16'($urandom),
                                  sm, tm, ms, lim, arm));
    endtask

    task automatic other(logic [1:0] c, logic [15:0] tm);
        pending_reqs.push_back(mk(c, 16'($urandom), 16'($urandom), 16'($urandom), tm,
                                  16'($urandom), 16'($urandom), 1'($urandom_range(1))));
    endtask

    function automatic logic signed [15:0] rand_current(int unsigned lim);
        int unsigned r;
        int m;
        r = $urandom_range(99);
        if (r < 60) m = int'($urandom_range(lim * 7 / 10));
        else if (r < 90) m = int'($urandom_range(32767, lim + 1 > 32767 ? 32767 : lim + 1));
        else return 16'($urandom);
        return $urandom_range(1) ? 16'(m) : 16'(-m);
    endfunction

    task automatic random_traffic(int n);
        int goal, k, r;
        int unsigned lim;
        goal = pending_reqs.size() + n;
        while (pending_reqs.size() < goal) begin
            r = int'($urandom_range(99));
            lim = (lim_clamp < 30000) ? lim_clamp : 30000;
            if (r < 60) begin
                start($urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(20000)),
                      $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(20000)),
                      $urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(300)),
                      $urandom_range(2) == 0 ? 16'd0 : 16'($urandom_range(65535)),
                      1'($urandom_range(1)));
                k = int'($urandom_range(25, 3));
                repeat (k) tick($urandom_range(40, 1), rand_current(lim), rand_current(lim));
                if ($urandom_range(5) == 0)
                    repeat ($urandom_range(7, 3)) tick($urandom_range(500, 300), 16'sh7fff, 16'sh7fff);
            end else if (r < 75) begin
                other(mrcl_pkg::CMD_DIRECT,
                      $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(19500)));
            end else if (r < 85) begin
                other(mrcl_pkg::CMD_CANCEL, 16'($urandom));
            end else begin
                case ($urandom_range(3))
                    0: tick(0, rand_current(lim), rand_current(lim));
                    1: tick($urandom_range(5000, GAP_MAX + 1), rand_current(lim), rand_current(lim));
                    2: tick($urandom, 16'($urandom), 16'($urandom));
                    default: tick($urandom_range(GAP_MAX), 16'($urandom), 16'($urandom));
                endcase
            end
        end
        pending_reqs[goal - n + n / 2].drain = 1;
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || s_tvalid || expected_status.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        forever begin
            @(posedge aclk);
            if (cfg_ready) break;
        end
        cfg_valid <= 1'b0;
        case (idx)
            mrcl_pkg::REG_CLAMP_LIMIT: lim_clamp = val;
            mrcl_pkg::REG_DEFAULT_LIM: lim_default = val;
            default:                   tmo_ms = val;
        endcase
    endtask

    task automatic settings(logic [15:0] c, logic [15:0] d, logic [15:0] t);
        wait_idle();
        write_reg(mrcl_pkg::REG_CLAMP_LIMIT, c);
        write_reg(mrcl_pkg::REG_DEFAULT_LIM, d);
        write_reg(mrcl_pkg::REG_PAUSE_TMO, t);
    endtask

    initial begin : stimulus
        logic [95:0] pf, ps;
        pf = 96'd1 << 32;
        ps = 96'd1 << 32;
        for (int d = 0; d <= GAP_MAX; d++) begin
            if (d > 0) begin
                pf = (pf * mrcl_pkg::FAST_Q32 + (96'd1 << 31)) >> 32;
                ps = (ps * mrcl_pkg::SLOW_Q32 + (96'd1 << 31)) >> 32;
            end
            keep_q16[d] = 17'((pf + 96'd32768) >> 16);
            rise_q16[d] = 17'd65536 - 17'((ps + 96'd32768) >> 16);
        end
        lim_clamp = mrcl_pkg::CLAMP_LIMIT_RST;
        lim_default = mrcl_pkg::DEFAULT_LIM_RST;
        tmo_ms = mrcl_pkg::PAUSE_TMO_RST;
        applied = 0; ceiling = 16'hffff; clamp_t = 0; clamp_ok = 0;
        r_start = 0; r_end = 0; r_len = 0; r_lim = 0; r_origin = 0; p_begin = 0;
        r_act = 0; r_pau = 0; est_armed = 0;
        tnow = $urandom;

        // directed: first tick, gap cases, idle tick, ramp corner cases
        tick(0, 16'sh7fff, -16'sh8000);
        tick(0, 16'sd10, 16'sd10);
        tick(GAP_MAX + 1, 16'sd100, 16'sd0);
        tick(20, -16'sh8000, -16'sh8000);
        start(16'd0, 16'd8000, 16'd0, 16'd0, 1'b1);
        start(16'd5000, 16'd5001, 16'd100, 16'd500, 1'b0);
        other(mrcl_pkg::CMD_DIRECT, 16'hffff);
        other(mrcl_pkg::CMD_DIRECT, 16'd0);
        start(16'd1000, 16'd16000, 16'd100, 16'd0, 1'b1);
        tick(10, 16'sd50, 16'sd50);
        tick(10, 16'sd2000, -16'sd100);
        tick(30, 16'sd2000, 16'sd100);
        tick(10, 16'sd100, 16'sd100);
        tick(GAP_MAX, 16'sd10, -16'sd10);
        other(mrcl_pkg::CMD_CANCEL, 16'd0);
        start(16'hffff, 16'd0, 16'hffff, 16'hffff, 1'b1);
        tick(1, 16'sd0, 16'sd0);
        start(16'd0, 16'd12000, 16'd200, 16'd300, 1'b0);
        tick(5, 16'sd10, 16'sd10);
        repeat (6) tick(400, 16'sd3000, 16'sd3000);
        tick(20, 16'sd0, 16'sd0);
        tnow = 32'hffff_fff0;
        tick(30, 16'sd5, 16'sd5);
        pending_reqs[pending_reqs.size() - 1].drain = 1;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        random_traffic(150);
        settings(16'd400, 16'd600, 16'd300);
        calm = 1;
        random_traffic(100);
        wait_idle();
        calm = 0;
        settings(16'd0, 16'd1, 16'd1);
        random_traffic(120);
        settings(16'hffff, 16'hffff, 16'hffff);
        random_traffic(120);
        settings(16'($urandom_range(65535)), 16'($urandom_range(65535, 1)),
                 16'($urandom_range(65535, 1)));
        random_traffic(200);
        wait_idle();

        $display("%0d requests, %0d results, %0d ramps finished, %0d aborts, %0d cycles",
                 reqs_sent, results_seen, dones_seen, aborts_seen, cycles);
        $display("five register settings incl. extremes, %0d mismatches", mismatches);
        if (mismatches == 0 && expected_status.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/mrcl_pkg.sv
rtl/modulation_ramp_current_limiter_core.sv
dv/testbench.sv
